>>> src/stl_pkg.sv
// Shared constants and character classes for the script text lexer.
// No dependencies.
`default_nettype none
package stl_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_BITS    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int DECIDE_PASSES = 6;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_STRING  = 4'd2;
    localparam logic [3:0] M_ESCAPE  = 4'd3;
    localparam logic [3:0] M_IDENT   = 4'd4;
    localparam logic [3:0] M_NUMSTART= 4'd5;
    localparam logic [3:0] M_HEXX    = 4'd6;
    localparam logic [3:0] M_HEX     = 4'd7;
    localparam logic [3:0] M_INT     = 4'd8;
    localparam logic [3:0] M_FRAC    = 4'd9;
    localparam logic [3:0] M_EXPSIGN = 4'd10;
    localparam logic [3:0] M_EXP     = 4'd11;

    localparam logic [3:0] T_EOF     = 4'd0;
    localparam logic [3:0] T_EOL     = 4'd1;
    localparam logic [3:0] T_IDENT   = 4'd2;
    localparam logic [3:0] T_INT     = 4'd3;
    localparam logic [3:0] T_HEX     = 4'd4;
    localparam logic [3:0] T_FLOAT   = 4'd5;
    localparam logic [3:0] T_STRING  = 4'd6;
    localparam logic [3:0] T_PUNCT   = 4'd7;
    localparam logic [3:0] T_INVALID = 4'd8;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
               ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
    endfunction

endpackage
`default_nettype wire

>>> src/stl_if.sv
// Handshake interfaces of the lexer: text bytes in, tokens out, mode writes.
// Independent of the package.
`default_nettype none
interface stl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface stl_cfg_if;
    logic valid;
    logic ready;
    logic report_line_ends;
    modport source (output valid, output report_line_ends, input ready);
    modport sink   (input valid, input report_line_ends, output ready);
endinterface

interface stl_tok_if #(parameter int POSITION_BITS = 16);
    logic                     valid;
    logic                     ready;
    logic                     has_value_byte;
    logic [7:0]               value_byte;
    logic                     token_done;
    logic [3:0]               token_type;
    logic [POSITION_BITS-1:0] lead_line;
    logic [POSITION_BITS-1:0] lead_column;
    logic [POSITION_BITS-1:0] end_line;
    logic [POSITION_BITS-1:0] end_column;
    logic                     last_of_run;
    modport source (output valid, output has_value_byte, output value_byte,
                    output token_done, output token_type, output lead_line,
                    output lead_column, output end_line, output end_column,
                    output last_of_run, input ready);
    modport sink   (input valid, input has_value_byte, input value_byte,
                    input token_done, input token_type, input lead_line,
                    input lead_column, input end_line, input end_column,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

>>> src/stl_front.sv
// Lexer front end: accepts bytes, decides the pending byte, builds result bundles.
// Uses stl_pkg and stl_if.
`default_nettype none
module stl_front #(
    parameter int POSITION_BITS = 16,
    parameter int BUNDLE_BITS   = 4 * (15 + 4 * POSITION_BITS) + 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    stl_byte_if.sink                    text_in,
    stl_cfg_if.sink                     cfg,
    output logic                        push,
    output logic [BUNDLE_BITS-1:0]      bundle,
    input  wire logic                   full
);
    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};
    localparam logic [P-1:0] POS_ONE = {{(P-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [3:0]   mode;
        logic [3:0]   rtype;
        logic [P-1:0] line;
        logic [P-1:0] col;
        logic [P-1:0] sline;
        logic [P-1:0] scol;
    } lst_t;

    typedef struct packed {
        lst_t         s;
        logic         again;
        logic         ev;
        logic [7:0]   vb;
        logic         ed;
        logic [3:0]   dt;
        logic [P-1:0] el;
        logic [P-1:0] ec;
    } stp_t;

    typedef struct packed {
        logic         hv;
        logic [7:0]   vb;
        logic         done;
        logic [3:0]   ttype;
        logic [P-1:0] fl;
        logic [P-1:0] fc;
        logic [P-1:0] el;
        logic [P-1:0] ec;
        logic         last;
    } item_t;

    typedef struct packed {
        item_t [stl_pkg::MAX_RESULTS-1:0] it;
        logic [stl_pkg::CNT_BITS-1:0]     cnt;
    } bundle_t;

    function automatic stp_t step(input lst_t st, input logic [7:0] c,
                                  input logic [7:0] nx, input logic rle);
        stp_t r;
        logic adv;
        logic eof;
        r = '0;
        r.s = st;
        adv = 1'b0;
        eof = 1'b0;
        case (st.mode)
            stl_pkg::M_COMMENT: begin
                if (c == stl_pkg::CH_NL || c == stl_pkg::CH_NUL) begin
                    r.s.mode = stl_pkg::M_IDLE;
                    r.again = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
            stl_pkg::M_STRING: begin
                if (c == stl_pkg::CH_NUL || c == stl_pkg::CH_NL) begin
                    r.ed = 1'b1; r.dt = stl_pkg::T_INVALID; r.again = 1'b1;
                end else if (c == stl_pkg::CH_DQUOTE) begin
                    adv = 1'b1; r.ed = 1'b1; r.dt = stl_pkg::T_STRING;
                end else if (c == stl_pkg::CH_BSLASH) begin
                    adv = 1'b1; r.s.mode = stl_pkg::M_ESCAPE;
                end else begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                end
            end
            stl_pkg::M_ESCAPE: begin
                if (c == stl_pkg::CH_NL) begin
                    adv = 1'b1; r.s.mode = stl_pkg::M_STRING;
                end else if (c == stl_pkg::CH_SQUOTE || c == stl_pkg::CH_DQUOTE ||
                             c == stl_pkg::CH_BSLASH) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1; r.s.mode = stl_pkg::M_STRING;
                end else if (c == stl_pkg::CH_LN) begin
                    r.ev = 1'b1; r.vb = stl_pkg::CH_NL; adv = 1'b1;
                    r.s.mode = stl_pkg::M_STRING;
                end else if (c == stl_pkg::CH_LT) begin
                    r.ev = 1'b1; r.vb = stl_pkg::CH_TAB; adv = 1'b1;
                    r.s.mode = stl_pkg::M_STRING;
                end else begin
                    r.ed = 1'b1; r.dt = stl_pkg::T_INVALID; r.again = 1'b1;
                end
            end
            stl_pkg::M_IDENT: begin
                if (stl_pkg::is_ident_char(c)) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                end else begin
                    r.ed = 1'b1; r.dt = stl_pkg::T_IDENT; r.again = 1'b1;
                end
            end
            stl_pkg::M_NUMSTART: begin
                if (c == 8'h30 && (nx == stl_pkg::CH_LX || nx == stl_pkg::CH_UX)) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                    r.s.rtype = stl_pkg::T_HEX; r.s.mode = stl_pkg::M_HEXX;
                end else begin
                    r.s.rtype = stl_pkg::T_INT; r.s.mode = stl_pkg::M_INT;
                    r.again = 1'b1;
                end
            end
            stl_pkg::M_HEXX: begin
                r.ev = 1'b1; r.vb = c; adv = 1'b1; r.s.mode = stl_pkg::M_HEX;
            end
            stl_pkg::M_HEX: begin
                if (stl_pkg::is_xdigit(c)) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                end else begin
                    r.ed = 1'b1; r.dt = stl_pkg::T_HEX; r.again = 1'b1;
                end
            end
            stl_pkg::M_INT, stl_pkg::M_FRAC: begin
                if (stl_pkg::is_digit(c)) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                end else if (st.mode == stl_pkg::M_INT && c == stl_pkg::CH_DOT &&
                             stl_pkg::is_digit(nx)) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                    r.s.rtype = stl_pkg::T_FLOAT; r.s.mode = stl_pkg::M_FRAC;
                end else if (c == stl_pkg::CH_LE || c == stl_pkg::CH_UE) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                    r.s.rtype = stl_pkg::T_FLOAT; r.s.mode = stl_pkg::M_EXPSIGN;
                end else begin
                    r.ed = 1'b1; r.dt = st.rtype; r.again = 1'b1;
                end
            end
            stl_pkg::M_EXPSIGN: begin
                r.s.mode = stl_pkg::M_EXP;
                if (c == stl_pkg::CH_PLUS || c == stl_pkg::CH_MINUS) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                end else begin
                    r.again = 1'b1;
                end
            end
            stl_pkg::M_EXP: begin
                if (stl_pkg::is_digit(c)) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                end else begin
                    r.ed = 1'b1; r.dt = stl_pkg::T_FLOAT; r.again = 1'b1;
                end
            end
            default: begin
                r.s.mode = stl_pkg::M_IDLE;
                r.s.sline = st.line;
                r.s.scol = st.col;
                if (c == stl_pkg::CH_NUL) begin
                    r.ed = 1'b1; r.dt = stl_pkg::T_EOF; eof = 1'b1;
                end else if (c == stl_pkg::CH_NL && rle) begin
                    adv = 1'b1; r.ed = 1'b1; r.dt = stl_pkg::T_EOL;
                end else if (stl_pkg::is_space(c)) begin
                    adv = 1'b1;
                end else if (c == stl_pkg::CH_HASH) begin
                    adv = 1'b1; r.s.mode = stl_pkg::M_COMMENT;
                end else if (c == stl_pkg::CH_DQUOTE) begin
                    adv = 1'b1; r.s.rtype = stl_pkg::T_STRING;
                    r.s.mode = stl_pkg::M_STRING;
                end else if (stl_pkg::is_alpha(c) || c == stl_pkg::CH_UNDER) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                    r.s.rtype = stl_pkg::T_IDENT; r.s.mode = stl_pkg::M_IDENT;
                end else if (stl_pkg::is_digit(c)) begin
                    r.s.mode = stl_pkg::M_NUMSTART; r.again = 1'b1;
                end else if (stl_pkg::is_punct(c)) begin
                    r.ev = 1'b1; r.vb = c; adv = 1'b1;
                    if (c == stl_pkg::CH_MINUS && stl_pkg::is_digit(nx)) begin
                        r.s.rtype = stl_pkg::T_INT; r.s.mode = stl_pkg::M_NUMSTART;
                    end else begin
                        r.ed = 1'b1; r.dt = stl_pkg::T_PUNCT;
                    end
                end else begin
                    adv = 1'b1; r.ed = 1'b1; r.dt = stl_pkg::T_INVALID;
                end
            end
        endcase
        if (adv) begin
            if (r.s.col < POS_MAX) r.s.col = r.s.col + POS_ONE;
            if (c == stl_pkg::CH_NL) begin
                if (r.s.line < POS_MAX) r.s.line = r.s.line + POS_ONE;
                r.s.col = POS_ONE;
            end
        end
        if (r.ed) r.s.mode = stl_pkg::M_IDLE;
        r.el = r.s.line;
        r.ec = r.s.col;
        if (eof) begin
            r.s.line = POS_ONE;
            r.s.col = POS_ONE;
        end
        return r;
    endfunction

    lst_t       st_reg, st_next;
    logic [7:0] pend_reg;
    logic       have_reg;
    logic       rle_reg;
    bundle_t    bnd;
    logic       accept;

    assign text_in.ready = !full;
    assign cfg.ready = 1'b1;
    assign accept = text_in.valid && !full;

    always_comb
    begin
        lst_t                         cur;
        stp_t                         s;
        logic                         act;
        logic [stl_pkg::CNT_BITS-1:0] n;
        cur = st_reg;
        act = 1'b1;
        n = '0;
        bnd = '0;
        for (int k = 0; k < stl_pkg::DECIDE_PASSES; k++) begin
            if (act) begin
                s = step(cur, pend_reg, text_in.text_byte, rle_reg);
                if (s.ev && n < stl_pkg::CNT_BITS'(stl_pkg::MAX_RESULTS)) begin
                    bnd.it[n[1:0]].hv = 1'b1;
                    bnd.it[n[1:0]].vb = s.vb;
                    n = n + 1'b1;
                end
                if (s.ed && n < stl_pkg::CNT_BITS'(stl_pkg::MAX_RESULTS)) begin
                    bnd.it[n[1:0]].done = 1'b1;
                    bnd.it[n[1:0]].ttype = s.dt;
                    bnd.it[n[1:0]].fl = s.s.sline;
                    bnd.it[n[1:0]].fc = s.s.scol;
                    bnd.it[n[1:0]].el = s.el;
                    bnd.it[n[1:0]].ec = s.ec;
                    n = n + 1'b1;
                end
                cur = s.s;
                act = s.again;
            end
        end
        if (n != '0) bnd.it[n[1:0] - 2'd1].last = 1'b1;
        bnd.cnt = n;
        st_next = cur;
    end

    assign bundle = BUNDLE_BITS'(bnd);
    assign push = accept && have_reg && (bnd.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= '{mode: stl_pkg::M_IDLE, rtype: stl_pkg::T_EOF, line: POS_ONE,
                        col: POS_ONE, sline: POS_ONE, scol: POS_ONE};
            pend_reg <= '0;
            have_reg <= 1'b0;
            rle_reg <= 1'b0;
        end else begin
            if (cfg.valid) rle_reg <= cfg.report_line_ends;
            if (accept) begin
                pend_reg <= text_in.text_byte;
                have_reg <= 1'b1;
                if (have_reg) st_reg <= st_next;
            end
        end
    end
endmodule
`default_nettype wire

>>> src/stl_queue.sv
// Short FIFO of result bundles between lexer front and back ends.
// Uses stl_pkg.
`default_nettype none
module stl_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  full,
    output logic                  empty
);
    logic [WIDTH-1:0]              mem_reg [stl_pkg::QUEUE_DEPTH];
    logic [stl_pkg::QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [stl_pkg::QPTR_BITS:0]   cnt_reg;

    assign full = (cnt_reg == (stl_pkg::QPTR_BITS+1)'(stl_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> src/stl_back.sv
// Lexer back end: unpacks result bundles into single requests on the output register.
// Uses stl_pkg and stl_if.
`default_nettype none
module stl_back #(
    parameter int POSITION_BITS = 16,
    parameter int BUNDLE_BITS   = 4 * (15 + 4 * POSITION_BITS) + 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [BUNDLE_BITS-1:0] head,
    input  wire logic                   empty,
    output logic                        pop,
    stl_tok_if.source                   token_out
);
    localparam int P = POSITION_BITS;

    typedef struct packed {
        logic         hv;
        logic [7:0]   vb;
        logic         done;
        logic [3:0]   ttype;
        logic [P-1:0] fl;
        logic [P-1:0] fc;
        logic [P-1:0] el;
        logic [P-1:0] ec;
        logic         last;
    } item_t;

    typedef struct packed {
        item_t [stl_pkg::MAX_RESULTS-1:0] it;
        logic [stl_pkg::CNT_BITS-1:0]     cnt;
    } bundle_t;

    bundle_t    b;
    item_t      out_reg;
    logic       vld_reg;
    logic [1:0] sub_reg;
    logic       take;

    assign b = bundle_t'(head);
    assign take = !empty && (!vld_reg || token_out.ready);
    assign pop = take && ({1'b0, sub_reg} == b.cnt - 1'b1);

    always_ff @(posedge clk)
    begin
        if (take) out_reg <= b.it[sub_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
            sub_reg <= '0;
        end else begin
            if (take) begin
                vld_reg <= 1'b1;
                sub_reg <= pop ? 2'd0 : sub_reg + 2'd1;
            end else if (token_out.ready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    assign token_out.valid = vld_reg;
    assign token_out.has_value_byte = out_reg.hv;
    assign token_out.value_byte = out_reg.vb;
    assign token_out.token_done = out_reg.done;
    assign token_out.token_type = out_reg.ttype;
    assign token_out.lead_line = out_reg.fl;
    assign token_out.lead_column = out_reg.fc;
    assign token_out.end_line = out_reg.el;
    assign token_out.end_column = out_reg.ec;
    assign token_out.last_of_run = out_reg.last;
endmodule
`default_nettype wire

>>> src/script_text_lexer.sv
// Script text lexer top level: front end, bundle queue, back end.
// Uses stl_pkg, stl_if, stl_front, stl_queue, stl_back.
//
// One text byte is taken per cycle while the four-entry bundle queue has room; each byte
// is decided against the next one as lookahead, and its requests (value bytes and done
// requests with type and positions, in the order they arise) leave the output register
// at one per cycle while token_out.ready is high. Taking the first byte after reset
// pushes nothing; bytes that cause nothing produce no output. report_line_ends must be
// written over the cfg channel only while idle; the block itself does not enforce it.
`default_nettype none
module script_text_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stl_byte_if.sink  text_in,
    stl_cfg_if.sink   cfg,
    stl_tok_if.source token_out
);
    localparam int BW = stl_pkg::MAX_RESULTS * (15 + 4 * POSITION_BITS) + stl_pkg::CNT_BITS;

    logic          push, pop, full, empty;
    logic [BW-1:0] wr_bundle, rd_bundle;

    stl_front #(.POSITION_BITS(POSITION_BITS), .BUNDLE_BITS(BW)) u_front (
        .clk(clk), .rst_n(rst_n), .text_in(text_in), .cfg(cfg),
        .push(push), .bundle(wr_bundle), .full(full)
    );

    stl_queue #(.WIDTH(BW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wr_data(wr_bundle),
        .pop(pop), .rd_data(rd_bundle), .full(full), .empty(empty)
    );

    stl_back #(.POSITION_BITS(POSITION_BITS), .BUNDLE_BITS(BW)) u_back (
        .clk(clk), .rst_n(rst_n), .head(rd_bundle), .empty(empty),
        .pop(pop), .token_out(token_out)
    );
endmodule
`default_nettype wire
